// ----- sv/tlru_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, reset values and the lookup result type for the LRU TLB.
package tlru_pkg;

    localparam int PAGE_W          = 32;
    localparam int COUNT_W         = 32;
    localparam int CFG_W           = 5;
    localparam int DEFAULT_ENTRIES = 16;

    localparam logic [CFG_W-1:0]   CAP_RESET = CFG_W'(16);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Result of one lookup in the recency chain
    typedef struct packed {
        logic              hit;
        logic              evict_valid;
        logic [PAGE_W-1:0] evict_page;
    } tlru_result_t;

endpackage

// ----- sv/tlru_cell.sv -----
`timescale 1ns / 1ps
// One slot of the recency chain: a page tag, its valid bit and a tag compare.
module tlru_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      shift_en,
    input  logic                      flush,
    input  logic                      prev_valid,
    input  logic [tlru_pkg::PAGE_W-1:0] prev_page,
    input  logic [tlru_pkg::PAGE_W-1:0] lookup_page,
    output logic                      valid,
    output logic [tlru_pkg::PAGE_W-1:0] page,
    output logic                      match
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [tlru_pkg::PAGE_W-1:0] page_reg;
    logic [tlru_pkg::PAGE_W-1:0] page_next;

    always_comb
    begin
        valid_next = valid_reg;
        page_next  = page_reg;
        if (shift_en)
        begin
            valid_next = prev_valid;
            page_next  = prev_page;
        end
        else if (flush)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    // a flushed slot counts as empty for the request that flushes it
    assign match = valid_reg && !flush && (page_reg == lookup_page);
    assign valid = valid_reg;
    assign page  = page_reg;

endmodule

// ----- sv/tlru_chain.sv -----
`timescale 1ns / 1ps
// Recency chain: slot 0 is most recent, occupied slots are contiguous from 0.
module tlru_chain #(
    parameter int TLB_ENTRIES = tlru_pkg::DEFAULT_ENTRIES,
    parameter int OCC_W       = $clog2(TLB_ENTRIES + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        access,
    input  logic                        flush,
    input  logic                        full,
    input  logic [OCC_W-1:0]            occ,
    input  logic [tlru_pkg::PAGE_W-1:0] lookup_page,
    output tlru_pkg::tlru_result_t      result
);

    localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    logic [TLB_ENTRIES-1:0]      cell_valid;
    logic [TLB_ENTRIES-1:0]      cell_match;
    logic [TLB_ENTRIES-1:0]      cell_shift;
    logic [tlru_pkg::PAGE_W-1:0] cell_page [TLB_ENTRIES];
    logic [IDX_W-1:0]            hit_idx;
    logic [IDX_W-1:0]            evict_idx;
    logic [OCC_W-1:0]            shift_pos;
    logic                        hit;
    logic                        evict;

    genvar g;
    generate
        for (g = 0; g < TLB_ENTRIES; g++)
        begin : g_cell
            logic                        in_valid;
            logic [tlru_pkg::PAGE_W-1:0] in_page;

            if (g == 0)
            begin : g_head
                assign in_valid = 1'b1;
                assign in_page  = lookup_page;
            end
            else
            begin : g_body
                assign in_valid = cell_valid[g-1];
                assign in_page  = cell_page[g-1];
            end

            assign cell_shift[g] = access && (OCC_W'(g) <= shift_pos);

            tlru_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .shift_en    (cell_shift[g]),
                .flush       (flush),
                .prev_valid  (in_valid),
                .prev_page   (in_page),
                .lookup_page (lookup_page),
                .valid       (cell_valid[g]),
                .page        (cell_page[g]),
                .match       (cell_match[g])
            );
        end
    endgenerate

    // tags are unique, so an OR encoder gives the matching slot
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            if (cell_match[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign hit       = |cell_match;
    assign evict     = full && !hit;
    assign evict_idx = IDX_W'(occ - OCC_W'(1));

    // slots up to this one move one step older; the request lands in slot 0
    always_comb
    begin
        if (hit)
        begin
            shift_pos = OCC_W'(hit_idx);
        end
        else if (full)
        begin
            shift_pos = occ - OCC_W'(1);
        end
        else
        begin
            shift_pos = occ;
        end
    end

    always_comb
    begin
        result.hit         = hit;
        result.evict_valid = evict;
        result.evict_page  = evict ? cell_page[evict_idx] : '0;
    end

`ifndef NO_ASSERTIONS
    a_valid_count : assert property (@(posedge clk) disable iff (!rst_n)
        !flush |-> ($countones(cell_valid) == int'(occ)))
        else $error("valid slots disagree with occupancy");
`endif

endmodule

// ----- sv/tlru_lru_replacement_dummy_guard.sv -----
`timescale 1ns / 1ps
// Saturating per-trace hit counter.
module tlru_hit_counter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         access,
    input  logic                         flush,
    input  logic                         hit,
    output logic [tlru_pkg::COUNT_W-1:0] count_next,
    output logic [tlru_pkg::COUNT_W-1:0] count
);

    logic [tlru_pkg::COUNT_W-1:0] count_reg;
    logic [tlru_pkg::COUNT_W-1:0] count_base;

    always_comb
    begin
        count_base = flush ? '0 : count_reg;
        count_next = count_base;
        if (hit && (count_base != tlru_pkg::COUNT_MAX))
        begin
            count_next = count_base + tlru_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (access)
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// ----- sv/tlb_lru_replacement.sv -----
`timescale 1ns / 1ps
// Top level of the fully associative LRU TLB with its output register.
//
// Fully associative TLB of page tags with true LRU replacement, built as a
// chain of slots ordered by recency: slot 0 holds the most recently used page
// and the occupied slots run contiguously behind it. Each request compares
// its page against every slot at once; the slots in front of the hit (or of
// the victim, or of the first free slot) each hand their tag one step down
// the chain and the page lands in slot 0. A miss with the table full (at the
// capacity set by entries_in_use, where 0 acts as 1 and anything above
// TLB_ENTRIES acts as TLB_ENTRIES) evicts the deepest occupied slot and
// reports its page. first_of_trace empties the table and zeroes the hit
// count before its own lookup. Rate: one request per clock while in_stall is
// low; the tag compare across all slots and the one-step chain shift finish
// in the cycle the request is taken, and the result goes into the output
// register. A request is taken while the output register is empty or being
// drained, so in_stall only follows out_stall. entries_in_use is written
// over its own port, which is always ready, and should change only while
// no request is in flight.
module tlb_lru_replacement #(
    parameter int TLB_ENTRIES = tlru_pkg::DEFAULT_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tlru_pkg::CFG_W-1:0]   entries_in_use,
    // request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tlru_pkg::PAGE_W-1:0]  page_number,
    input  logic                         first_of_trace,
    input  logic                         last_of_trace,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         hit,
    output logic                         evicted_valid,
    output logic [tlru_pkg::PAGE_W-1:0]  evicted_page,
    output logic [tlru_pkg::COUNT_W-1:0] hit_count,
    output logic                         trace_done
);

    localparam int OCC_W = $clog2(TLB_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > tlru_pkg::CFG_W) ? OCC_W : tlru_pkg::CFG_W;

    // configuration
    logic [tlru_pkg::CFG_W-1:0]   cap_reg;
    logic [tlru_pkg::CFG_W-1:0]   cap_next;
    logic [CMP_W-1:0]             cap_eff;

    // control
    logic                         accept;
    logic                         flush;
    logic                         full;
    logic [OCC_W-1:0]             occ_reg;
    logic [OCC_W-1:0]             occ_next;
    logic [OCC_W-1:0]             occ_eff;
    tlru_pkg::tlru_result_t       result;
    logic [tlru_pkg::COUNT_W-1:0] count_next;
    logic [tlru_pkg::COUNT_W-1:0] count_cur;

    // output register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         hit_reg;
    logic                         evicted_valid_reg;
    logic [tlru_pkg::PAGE_W-1:0]  evicted_page_reg;
    logic [tlru_pkg::COUNT_W-1:0] hit_count_reg;
    logic                         trace_done_reg;

    assign cfg_ready = 1'b1;
    assign cap_next  = (cfg_valid && cfg_ready) ? entries_in_use : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= tlru_pkg::CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // clamp capacity to 1..TLB_ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(TLB_ENTRIES))
        begin
            cap_eff = CMP_W'(TLB_ENTRIES);
        end
        else
        begin
            cap_eff = CMP_W'(cap_reg);
        end
    end

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign flush    = accept && first_of_trace;
    assign occ_eff  = flush ? '0 : occ_reg;
    assign full     = (CMP_W'(occ_eff) >= cap_eff);

    tlru_chain #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .OCC_W       (OCC_W)
    ) u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .access      (accept),
        .flush       (flush),
        .full        (full),
        .occ         (occ_eff),
        .lookup_page (page_number),
        .result      (result)
    );

    tlru_hit_counter u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .access     (accept),
        .flush      (flush),
        .hit        (result.hit),
        .count_next (count_next),
        .count      (count_cur)
    );

    // occupancy grows only on a miss with room to spare
    assign occ_next = (!result.hit && !full) ? occ_eff + OCC_W'(1) : occ_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (accept)
        begin
            occ_reg <= occ_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg           <= result.hit;
            evicted_valid_reg <= result.evict_valid;
            evicted_page_reg  <= result.evict_page;
            hit_count_reg     <= count_next;
            trace_done_reg    <= last_of_trace;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign hit_count     = hit_count_reg;
    assign trace_done    = trace_done_reg;

`ifndef NO_ASSERTIONS
    a_occ_bound : assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_reg) <= TLB_ENTRIES)
        else $error("occupancy above table size");

    a_hit_no_evict : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !(hit_reg && evicted_valid_reg))
        else $error("request both hit and evicted");

    a_count_tracks : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (hit_count_reg == count_cur))
        else $error("reported hit count differs from counter");

    a_evict_full : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.evict_valid) |=> (occ_reg == $past(occ_reg)))
        else $error("eviction changed occupancy");
`endif

endmodule
